// ----- sv/cdo_pkg.sv -----
`timescale 1ns / 1ps

package cdo_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_SUB     = 2'd2;
  localparam logic [1:0] CMD_COMPARE = 2'd3;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_LONG = 5'd31;

  // floor(y / 100) is (y * RECIP_100) >> 22 for every 14-bit year.
  localparam logic [15:0] RECIP_100 = 16'd41944;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_A,
    ST_LEAP_B,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [11:0] rem;
    logic        done;
    logic        year_chg;
    logic        range_err;
  } step_out_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/calendar_date_day_offset.sv -----
`timescale 1ns / 1ps
// Channel  Direction  tdata (lowest bit up)                          tuser
// s_*      in         in_day, in_month, in_year, day_count (40 bits)   cmd
// m_*      out        out_day, out_month, out_year, order (32 bits)    range_error
//
// Compare goes from acceptance straight to ST_FINISH, which loads the result register; load first
// passes ST_LEAP_A, ST_LEAP_B and ST_CHECK. Add and subtract pass the leap-year states, then walk
// the months, one per cycle, and rerun the leap-year unit (ST_LEAP_A, ST_LEAP_B) at each year boundary.
// Reset restores the held date to 1 January 2001 and empties the result register.
// s_tready is high only while idle; a waiting result holds in m_tdata until taken.

module calendar_date_day_offset #(
  parameter int MAX_OFFSET = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // in_day, in_month, in_year, day_count, zero pad
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_day, out_month, out_year, order, zero pad
  output logic        m_tuser    // range_error
);

  localparam logic [16:0] MaxOff = 17'(MAX_OFFSET);

  cdo_pkg::state_t    state;
  cdo_pkg::state_t    state_next;
  cdo_pkg::step_out_t step;

  logic [1:0]  cmd_r;
  logic [4:0]  op_day;
  logic [3:0]  op_month;
  logic [13:0] op_year;
  logic [4:0]  work_day;
  logic [3:0]  work_month;
  logic [13:0] work_year;
  logic [11:0] rem;
  logic        leap_r;
  logic        err_r;
  logic [4:0]  held_day;
  logic [3:0]  held_month;
  logic [13:0] held_year;

  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [13:0] in_year;
  logic [11:0] day_count;
  logic [11:0] count_sat;
  logic        leap;
  logic        load_ok;
  logic [1:0]  order;
  logic        out_load;

  assign in_day    = s_tdata[4:0];
  assign in_month  = s_tdata[8:5];
  assign in_year   = s_tdata[22:9];
  assign day_count = s_tdata[34:23];

  cdo_leap u_leap (
    .clk  (clk),
    .year (work_year),
    .leap (leap)
  );

  cdo_step u_step (
    .dir_back (cmd_r == cdo_pkg::CMD_SUB),
    .day      (work_day),
    .month    (work_month),
    .year     (work_year),
    .rem      (rem),
    .leap     (leap_r),
    .res      (step)
  );

  always_comb begin
    s_tready  = (state == cdo_pkg::ST_IDLE);
    count_sat = ({5'b0, day_count} > MaxOff) ? MaxOff[11:0] : day_count;
    out_load  = (state == cdo_pkg::ST_FINISH) && (!m_tvalid || m_tready);

    load_ok = (work_month >= cdo_pkg::MONTH_JAN) && (work_month <= cdo_pkg::MONTH_DEC) &&
              (work_year >= cdo_pkg::YEAR_MIN) && (work_year <= cdo_pkg::YEAR_MAX) &&
              (work_day != 5'd0) &&
              (work_day <= cdo_pkg::days_in(work_month, leap_r));

    if (held_year != op_year) begin
      order = (held_year < op_year) ? cdo_pkg::ORD_LESS : cdo_pkg::ORD_GREATER;
    end else if (held_month != op_month) begin
      order = (held_month < op_month) ? cdo_pkg::ORD_LESS : cdo_pkg::ORD_GREATER;
    end else if (held_day != op_day) begin
      order = (held_day < op_day) ? cdo_pkg::ORD_LESS : cdo_pkg::ORD_GREATER;
    end else begin
      order = cdo_pkg::ORD_EQUAL;
    end

    state_next = state;
    case (state)
      cdo_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == cdo_pkg::CMD_COMPARE) ? cdo_pkg::ST_FINISH
                                                         : cdo_pkg::ST_LEAP_A;
        end
      end
      cdo_pkg::ST_LEAP_A: state_next = cdo_pkg::ST_LEAP_B;
      cdo_pkg::ST_LEAP_B: begin
        state_next = (cmd_r == cdo_pkg::CMD_LOAD) ? cdo_pkg::ST_CHECK : cdo_pkg::ST_WALK;
      end
      cdo_pkg::ST_CHECK: state_next = cdo_pkg::ST_FINISH;
      cdo_pkg::ST_WALK: begin
        if (step.range_err || step.done) begin
          state_next = cdo_pkg::ST_FINISH;
        end else if (step.year_chg) begin
          state_next = cdo_pkg::ST_LEAP_A;
        end
      end
      cdo_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = cdo_pkg::ST_IDLE;
        end
      end
      default: state_next = cdo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cdo_pkg::ST_IDLE;
      m_tvalid   <= 1'b0;
      err_r      <= 1'b0;
      held_day   <= 5'd1;
      held_month <= 4'd1;
      held_year  <= 14'd2001;
    end else begin
      state <= state_next;

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        cdo_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r    <= s_tuser;
            op_day   <= in_day;
            op_month <= in_month;
            op_year  <= in_year;
            rem      <= count_sat;
            err_r    <= 1'b0;
            // A load is checked on a working copy so that a refused date leaves nothing behind.
            if (s_tuser == cdo_pkg::CMD_LOAD) begin
              work_day   <= in_day;
              work_month <= in_month;
              work_year  <= in_year;
            end else begin
              work_day   <= held_day;
              work_month <= held_month;
              work_year  <= held_year;
            end
          end
        end
        cdo_pkg::ST_LEAP_B: leap_r <= leap;
        cdo_pkg::ST_CHECK: begin
          if (load_ok) begin
            held_day   <= work_day;
            held_month <= work_month;
            held_year  <= work_year;
          end else begin
            err_r <= 1'b1;
          end
        end
        cdo_pkg::ST_WALK: begin
          if (step.range_err) begin
            err_r <= 1'b1;
          end else if (step.done) begin
            held_day   <= step.day;
            held_month <= step.month;
            held_year  <= step.year;
          end else begin
            work_day   <= step.day;
            work_month <= step.month;
            work_year  <= step.year;
            rem        <= step.rem;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, order, held_year, held_month, held_day};
      m_tuser <= err_r;
    end
  end

endmodule

// ----- sv/cdo_leap.sv -----
`timescale 1ns / 1ps

module cdo_leap (
  input  logic        clk,
  input  logic [13:0] year,
  output logic        leap
);

  logic [29:0] prod;
  logic [7:0]  quot;
  logic [13:0] year_r;
  logic [13:0] hundreds;
  logic [13:0] remainder;

  assign prod = {16'b0, year} * {14'b0, cdo_pkg::RECIP_100};

  // The quotient by 100 is registered before it is multiplied back.
  always_ff @(posedge clk) begin
    quot   <= prod[29:22];
    year_r <= year;
  end

  always_comb begin
    hundreds  = {quot, 6'b0} + {1'b0, quot, 5'b0} + {4'b0, quot, 2'b0};
    remainder = year_r - hundreds;
    // A century year is a leap year only when its century count is a multiple of four.
    if (remainder == 14'd0) begin
      leap = (quot[1:0] == 2'b00);
    end else begin
      leap = (year_r[1:0] == 2'b00);
    end
  end

endmodule

// ----- sv/cdo_step.sv -----
`timescale 1ns / 1ps

module cdo_step (
  input  logic                 dir_back,
  input  logic [4:0]           day,
  input  logic [3:0]           month,
  input  logic [13:0]          year,
  input  logic [11:0]          rem,
  input  logic                 leap,
  output cdo_pkg::step_out_t   res
);

  logic [4:0]  month_len;
  logic [12:0] sum;
  logic [5:0]  to_next;
  logic [3:0]  month_prev;

  always_comb begin
    month_len  = cdo_pkg::days_in(month, leap);
    sum        = {8'b0, day} + {1'b0, rem};
    to_next    = {1'b0, month_len} - {1'b0, day} + 6'd1;
    month_prev = month - 4'd1;

    res.day       = day;
    res.month     = month;
    res.year      = year;
    res.rem       = rem;
    res.done      = 1'b0;
    res.year_chg  = 1'b0;
    res.range_err = 1'b0;

    if (!dir_back) begin
      if (sum <= {8'b0, month_len}) begin
        res.day  = sum[4:0];
        res.done = 1'b1;
      end else begin
        res.rem = rem - {6'b0, to_next};
        res.day = 5'd1;
        if (month == cdo_pkg::MONTH_DEC) begin
          res.month    = cdo_pkg::MONTH_JAN;
          res.year     = year + 14'd1;
          res.year_chg = 1'b1;
          res.range_err = (year >= cdo_pkg::YEAR_MAX);
        end else begin
          res.month = month + 4'd1;
        end
      end
    end else begin
      if (rem >= {7'b0, day}) begin
        res.rem = rem - {7'b0, day};
        if (month == cdo_pkg::MONTH_JAN) begin
          // December is long in every year, so the leap flag can follow later.
          res.month     = cdo_pkg::MONTH_DEC;
          res.day       = cdo_pkg::DAYS_LONG;
          res.year      = year - 14'd1;
          res.year_chg  = 1'b1;
          res.range_err = (year <= cdo_pkg::YEAR_MIN);
        end else begin
          res.month = month_prev;
          res.day   = cdo_pkg::days_in(month_prev, leap);
        end
      end else begin
        res.day  = day - rem[4:0];
        res.done = 1'b1;
      end
    end
  end

endmodule
